>>> rtl/ost_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the ordered set table.
package ost_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                       found;
        logic signed [DATA_W-1:0]   read_value;
        status_t                    status;
        logic [COUNT_W-1:0]         entry_count;
    } res_t;

endpackage

>>> rtl/ost_store.sv
`timescale 1ns / 1ps
// Entry memory: one write port, one read port with registered read data.
module ost_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [ADDR_W-1:0]                 waddr,
    input  logic signed [ost_pkg::DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0]                 raddr,
    output logic signed [ost_pkg::DATA_W-1:0] rdata
);
    import ost_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ost_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: scans, shifts and reads the entry memory, and tracks occupancy.
module ost_ctrl #(
    parameter int CAPACITY = 64,
    parameter int ADDR_W   = 6,
    parameter int CNT_W    = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic signed [ost_pkg::DATA_W-1:0] value,
    input  logic [ost_pkg::POS_W-1:0]         position,
    output logic                              we,
    output logic [ADDR_W-1:0]                 waddr,
    output logic signed [ost_pkg::DATA_W-1:0] wdata,
    output logic [ADDR_W-1:0]                 raddr,
    input  logic signed [ost_pkg::DATA_W-1:0] rdata,
    output logic                              done,
    input  logic                              res_ready,
    output ost_pkg::res_t                     res
);
    import ost_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic                     found_reg, found_next;
    logic signed [DATA_W-1:0] rdv_reg, rdv_next;
    status_t                  status_reg, status_next;

    logic                     accept;
    op_t                      cur_op;
    logic signed [DATA_W-1:0] cur_value;
    logic                     match;
    logic [CNT_W-1:0]         occ_m1;
    logic [CNT_W-1:0]         occ_m2;
    logic                     last_idx;
    logic                     shift_last;
    logic                     table_full;
    logic                     table_empty;
    logic                     pos_hit;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     hit;
    logic                     miss;

    assign accept      = in_valid && (state_reg == S_IDLE);
    assign cur_op      = (state_reg == S_IDLE) ? op_t'(operation) : op_reg;
    assign cur_value   = (state_reg == S_IDLE) ? value : value_reg;
    assign match       = (rdata == value_reg);
    assign occ_m1      = occ_reg - CNT_W'(1);
    assign occ_m2      = occ_reg - CNT_W'(2);
    assign last_idx    = (idx_reg == ADDR_W'(occ_m1));
    assign shift_last  = (idx_reg == ADDR_W'(occ_m2));
    assign table_full  = (occ_reg == CNT_W'(CAPACITY));
    assign table_empty = (occ_reg == '0);
    assign pos_hit     = (CMP_W'(position) < CMP_W'(occ_reg));
    // position 0 is the newest entry, which sits at slot occupancy-1
    assign rd_addr     = ADDR_W'(CMP_W'(occ_reg) - CMP_W'(1) - CMP_W'(position));
    assign hit         = (state_reg == S_SCAN) && match;
    assign miss        = ((state_reg == S_SCAN) && !match && last_idx) ||
                         (accept && (cur_op != OP_READ) && table_empty);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cur_op == OP_READ)
                    begin
                        state_next = pos_hit ? S_READ : S_DONE;
                    end
                    else
                    begin
                        state_next = table_empty ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (op_reg == OP_REMOVE && !last_idx) ? S_SHIFT : S_DONE;
                end
                else if (last_idx)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        value_next  = value_reg;
        idx_next    = idx_reg;
        occ_next    = occ_reg;
        found_next  = found_reg;
        rdv_next    = rdv_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = rdata;
        raddr       = idx_reg + ADDR_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cur_op;
                    value_next  = value;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    rdv_next    = '0;
                    status_next = ST_OK;
                    raddr       = (cur_op == OP_READ) ? rd_addr : '0;
                    if (cur_op == OP_READ && !pos_hit)
                    begin
                        status_next = ST_MISS;
                    end
                end
            end
            S_SCAN:
            begin
                // hold the index on a hit so a remove shifts from the matched slot
                if (!hit)
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_SHIFT:
            begin
                // move the later entry down one slot, prefetch the one after
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = rdata;
                raddr    = idx_reg + ADDR_W'(2);
                idx_next = idx_reg + ADDR_W'(1);
                if (shift_last)
                begin
                    occ_next = occ_m1;
                end
            end
            S_READ:
            begin
                found_next = 1'b1;
                rdv_next   = rdata;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (hit)
        begin
            found_next = 1'b1;
            if (op_reg == OP_REMOVE && last_idx)
            begin
                occ_next = occ_m1;
            end
        end

        if (miss)
        begin
            if (cur_op == OP_INSERT)
            begin
                if (table_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    we       = 1'b1;
                    waddr    = ADDR_W'(occ_reg);
                    wdata    = cur_value;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            else
            begin
                status_next = ST_MISS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        rdv_reg    <= rdv_next;
        status_reg <= status_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign done     = (state_reg == S_DONE);
    assign res      = '{found:       found_reg,
                        read_value:  rdv_reg,
                        status:      status_reg,
                        entry_count: COUNT_W'(occ_reg)};

endmodule

>>> rtl/ordered_set_table.sv
`timescale 1ns / 1ps
// Bounded set of signed 32-bit values in newest-first order, one operation per
// input word and one result word per operation. Entries live in a single memory with one
// read and one write port; a search walks it one entry per cycle, and a remove then
// closes the gap one entry per cycle. A remove that finds its value shifts only the
// entries past the match. The memory needs no clearing after reset. A finished result
// waits in an output register, and the next word is taken while it waits.
module ordered_set_table #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic signed [ost_pkg::DATA_W-1:0] value,
    input  logic [ost_pkg::POS_W-1:0]         position,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic signed [ost_pkg::DATA_W-1:0] read_value,
    output logic [1:0]                        status,
    output logic [ost_pkg::COUNT_W-1:0]       entry_count
);
    import ost_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr;
    logic signed [DATA_W-1:0] rdata;
    logic                     done;
    logic                     res_ready;
    res_t                     res;

    logic                     out_valid_reg, out_valid_next;
    res_t                     res_out_reg;
    logic                     load;

    ost_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ost_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .value     (value),
        .position  (position),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr),
        .rdata     (rdata),
        .done      (done),
        .res_ready (res_ready),
        .res       (res)
    );

    // take a new result when the output register is empty or draining
    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = done && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = res_out_reg.found;
    assign read_value  = res_out_reg.read_value;
    assign status      = res_out_reg.status;
    assign entry_count = res_out_reg.entry_count;

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !done |=> !out_valid_reg)
        else $error("output register kept a word after it was taken");

    a_busy_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> in_stall)
        else $error("input taken while a result is pending");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_out_reg.status == ST_FULL |-> !res_out_reg.found)
        else $error("full status reported with found set");

    a_value_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_out_reg.read_value != '0
            |-> res_out_reg.found && res_out_reg.status == ST_OK)
        else $error("read value driven without a successful read");

endmodule

>>> tb/ordered_set_table_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ordered set table: directed cases, then random words.
module ordered_set_table_test;

    import ost_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;

    typedef logic signed [DATA_W-1:0] data_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          operation = OP_INSERT;
    data_t               value = '0;
    logic [POS_W-1:0]    position = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                found;
    data_t               read_value;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  entry_count;

    // Set contents as the block should hold them, newest first.
    data_t held_values[$];
    res_t  pending_results[$];
    res_t  oldest_result;

    bit calm = 1'b0;
    int errors = 0;
    int results_checked = 0;
    int words_per_op[4];
    int full_refusals = 0;
    int hits = 0;

    ordered_set_table #(
        .CAPACITY(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .value(value),
        .position(position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .read_value(read_value),
        .status(status),
        .entry_count(entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic res_t predict_result(op_t op, data_t v, logic [POS_W-1:0] pos);
        res_t r;
        int slot;
        r = '0;
        slot = -1;
        for (int i = 0; i < held_values.size(); i++)
        begin
            if (held_values[i] == v)
            begin
                slot = i;
                break;
            end
        end
        case (op)
            OP_INSERT:
            begin
                if (slot >= 0)
                    r.found = 1'b1;
                else if (held_values.size() >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                    held_values.push_front(v);
            end
            OP_REMOVE:
            begin
                if (slot >= 0)
                begin
                    r.found = 1'b1;
                    held_values.delete(slot);
                end
                else
                    r.status = ST_MISS;
            end
            OP_CONTAINS:
            begin
                if (slot >= 0)
                    r.found = 1'b1;
                else
                    r.status = ST_MISS;
            end
            default:
            begin
                if (pos < held_values.size())
                begin
                    r.found = 1'b1;
                    r.read_value = held_values[pos];
                end
                else
                    r.status = ST_MISS;
            end
        endcase
        r.entry_count = COUNT_W'(held_values.size());
        words_per_op[op]++;
        if (r.status == ST_FULL)
            full_refusals++;
        if (r.found)
            hits++;
        return r;
    endfunction

    // Drive one word at the falling edge and hold it until the block takes it.
    task automatic send_word(input op_t op, input data_t v, input int pos);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        value <= v;
        position <= POS_W'(pos);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_result(op, v, POS_W'(pos)));
    endtask

    // Bias toward values already held so removes and lookups hit.
    function automatic data_t pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && held_values.size() > 0)
            return held_values[$urandom_range(0, held_values.size() - 1)];
        else if (sel < 7)
            return $urandom_range(0, 80) - 40;
        else if (sel == 7)
            return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return $urandom;
    endfunction

    task automatic random_word(input int grow);
        op_t op;
        int pick;
        int pos;
        pick = $urandom_range(0, 99);
        if (pick < grow)
            op = OP_INSERT;
        else
        begin
            pick = $urandom_range(0, 9);
            op = pick < 4 ? OP_REMOVE : (pick < 7 ? OP_CONTAINS : OP_READ);
        end
        if (op == OP_READ && held_values.size() > 0 && $urandom_range(0, 9) < 7)
            pos = $urandom_range(0, held_values.size() - 1);
        else
            pos = $urandom_range(0, TABLE_DEPTH - 1);
        send_word(op, pick_value(), pos);
    endtask

    task automatic test_empty_table();
        send_word(OP_READ, $urandom, 0);
        send_word(OP_READ, $urandom, TABLE_DEPTH - 1);
        send_word(OP_REMOVE, 32'sd7, $urandom_range(0, 63));
        send_word(OP_CONTAINS, 32'sd0, $urandom_range(0, 63));
    endtask

    task automatic test_order_and_duplicates();
        send_word(OP_INSERT, 32'sh8000_0000, 0);
        send_word(OP_INSERT, 32'sh7fff_ffff, 63);
        send_word(OP_INSERT, 32'sd0, 0);
        send_word(OP_INSERT, -32'sd1, 0);
        send_word(OP_INSERT, 32'sh7fff_ffff, 0);
        send_word(OP_CONTAINS, 32'sh8000_0000, 0);
        send_word(OP_CONTAINS, 32'sd12345, 0);
        for (int p = 0; p <= 4; p++)
            send_word(OP_READ, $urandom, p);
        // Drop the middle entry; the rest must keep their order.
        send_word(OP_REMOVE, 32'sd0, 0);
        send_word(OP_READ, 32'sd0, 1);
        send_word(OP_REMOVE, -32'sd1, 0);
        send_word(OP_REMOVE, 32'sh8000_0000, 0);
        send_word(OP_REMOVE, 32'sh8000_0000, 0);
        send_word(OP_REMOVE, 32'sh7fff_ffff, 0);
    endtask

    task automatic test_full_table();
        logic [25:0] noise;
        data_t dup;
        // Distinct by construction: the index sits in the top bits.
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            noise = 26'($urandom);
            send_word(OP_INSERT, {i[5:0], noise}, 0);
        end
        send_word(OP_INSERT, 32'sh0c0f_fee0, 0);
        dup = held_values[17];
        send_word(OP_INSERT, dup, 0);
        send_word(OP_READ, 32'sd0, TABLE_DEPTH - 1);
        send_word(OP_READ, 32'sd0, 0);
        send_word(OP_CONTAINS, held_values[TABLE_DEPTH - 1], 0);
        send_word(OP_REMOVE, held_values[TABLE_DEPTH - 1], 0);
        send_word(OP_REMOVE, held_values[0], 0);
        send_word(OP_INSERT, -32'sd5, 0);
        send_word(OP_INSERT, 32'sd5, 0);
        send_word(OP_INSERT, 32'sd6, 0);
    endtask

    task automatic test_random_phases(input int rounds);
        for (int r = 0; r < rounds; r++)
        begin
            repeat (100) random_word(75);
            repeat (100) random_word(15);
            repeat (90) random_word(45);
        end
    endtask

    task automatic test_quiet_tail(input int count);
        calm = 1'b1;
        repeat (count) random_word(45);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_order_and_duplicates();
        test_full_table();
        test_random_phases(3);
        test_quiet_tail(150);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d inserts, %0d removes, %0d lookups, %0d reads; %0d results checked.",
                 words_per_op[OP_INSERT], words_per_op[OP_REMOVE],
                 words_per_op[OP_CONTAINS], words_per_op[OP_READ], results_checked);
        $display("%0d results reported a hit, %0d inserts were refused on a full set.",
                 hits, full_refusals);
        if (errors == 0)
            $display("ordered_set_table_test: PASS");
        else
            $display("ordered_set_table_test: FAIL");
        $finish;
    end

    // Random back-pressure on the result side; none once the run turns calm.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm && rst_n && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 30)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected (count %0d)", $time,
                         entry_count);
                errors++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                if (found !== oldest_result.found)
                begin
                    $display("%0t: found expected %0d, got %0d", $time,
                             oldest_result.found, found);
                    errors++;
                end
                if (read_value !== oldest_result.read_value)
                begin
                    $display("%0t: read_value expected %0d, got %0d", $time,
                             oldest_result.read_value, read_value);
                    errors++;
                end
                if (status !== oldest_result.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time,
                             oldest_result.status, status);
                    errors++;
                end
                if (entry_count !== oldest_result.entry_count)
                begin
                    $display("%0t: entry_count expected %0d, got %0d", $time,
                             oldest_result.entry_count, entry_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("ordered_set_table_test: FAIL");
        $finish;
    end

endmodule
